// ===== src/tdi_pkg.sv =====
// Shared constants and types for the timestamped delay interpolator.
// No dependencies; imported by the top level of the block.
`default_nettype none
package tdi_pkg;

	// Ring geometry
	localparam int DEPTH = 64;
	localparam int AW = $clog2(DEPTH);

	// Field widths
	localparam int TIME_W = 64;
	localparam int SAMP_W = 32;
	localparam int DELAY_W = 63;
	localparam int ENTRY_W = TIME_W + SAMP_W;
	localparam int PROD_W = SAMP_W + TIME_W;
	localparam int CNT_W = $clog2(PROD_W + 1);

	// Command codes
	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_STORE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Register indexes
	localparam logic REG_DELAY = 1'b0;
	localparam logic REG_INIT_VALUE = 1'b1;

	localparam logic [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
	localparam logic [33:0] MAG_LIMIT = 34'h2_0000_0000;

endpackage
`default_nettype wire

// ===== src/tdi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tdi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== src/timestamped_delay_interpolator.sv =====
// Top level of the timestamped delay interpolator: sequencer, datapath, ports.
// Depends on tdi_pkg and tdi_ram.
//
//  channel | direction | signals                                   | contents
//  s       | in        | s_tvalid s_tready s_tdata s_tuser         | request: command, time, sample
//  m       | out       | m_tvalid m_tready m_tdata                 | sample_out, buffer_short
//  cfg     | in        | cfg_valid cfg_ready cfg_index cfg_data    | delay_time, initial_value
//
// An init writes every ring entry; a store reads the newest entry and writes one; a read's duration
// is set by one RAM read per search probe and by the divider, which forms one bit per cycle; an
// unknown command goes straight to the output register.
// Reset clears the sequencer, head pointer, output valid and initial value, and sets the delay to 2^32; the ring
// is only defined after an init request. A request is taken only while the sequencer is idle;
// a finished result waits in the output register while the next request is taken, and a new
// result stalls until that register is free.
`default_nettype none
module timestamped_delay_interpolator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // now_time[63:0], sample_in[95:64]
	input  wire logic [1:0]  s_tuser,   // command[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // sample_out[31:0], buffer_short[32], zero pad
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	import tdi_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_INIT  = 16'h0002,
		S_RDH   = 16'h0004,
		S_CHK   = 16'h0008,
		S_NEWC  = 16'h0010,
		S_BSI   = 16'h0020,
		S_BSC   = 16'h0040,
		S_FJ    = 16'h0080,
		S_FGOT  = 16'h0100,
		S_MULLO = 16'h0200,
		S_MULHI = 16'h0400,
		S_DIV   = 16'h0800,
		S_FIN   = 16'h1000,
		S_EMIT  = 16'h2000
	} state_t;

	state_t state_q;

	logic [DELAY_W-1:0] delay_q;
	logic [SAMP_W-1:0]  init_val_q;
	logic [1:0]         cmd_q;
	logic [TIME_W-1:0]  now_q, td_q;
	logic [SAMP_W-1:0]  samp_q;
	logic [AW-1:0]      head_q, idx_q, lo_q, hi_q, k_q;
	logic [TIME_W-1:0]  acc_q;
	logic               sat_q;
	logic               short_q;
	logic [SAMP_W-1:0]  res_q;
	logic [TIME_W-1:0]  ti_q;
	logic [SAMP_W-1:0]  vi_q;
	logic [SAMP_W-1:0]  dv_q;
	logic [TIME_W-1:0]  b_q, del_q, rem_q;
	logic               neg_q;
	logic [PROD_W-1:0]  p_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [33:0]        quo_q;
	logic               ovf_q;
	logic               m_valid_q;
	logic [SAMP_W-1:0]  m_samp_q;
	logic               m_short_q;

	// RAM ports
	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [TIME_W-1:0]  rd_time;
	logic [SAMP_W-1:0]  rd_val;

	assign rd_time = ram_rdata[ENTRY_W-1:SAMP_W];
	assign rd_val  = ram_rdata[SAMP_W-1:0];

	tdi_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Ring index addition modulo DEPTH.
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// Signed difference x - y as a sign and a 64-bit magnitude.
	function automatic logic [TIME_W:0] sdiff(input logic [TIME_W-1:0] x,
			input logic [TIME_W-1:0] y);
		logic neg;
		logic [TIME_W-1:0] mag;
		neg = $signed(x) < $signed(y);
		mag = neg ? (y - x) : (x - y);
		return {neg, mag};
	endfunction

	// Delayed time of the incoming request, saturated at the most negative time.
	logic [TIME_W:0] td_wide;
	logic [TIME_W-1:0] td_in;
	assign td_wide = {s_tdata[TIME_W-1], s_tdata[TIME_W-1:0]} - {2'b00, delay_q};
	assign td_in = (td_wide[TIME_W] && !td_wide[TIME_W-1]) ? TIME_MIN : td_wide[TIME_W-1:0];

	// Init entry time from the running multiple of the delay.
	logic [TIME_W-1:0] init_m, init_time, acc_next;
	assign init_m = acc_q + TIME_W'(idx_q) + TIME_W'(1);
	assign init_time = (sat_q || init_m[TIME_W-1]) ? TIME_MIN : (~init_m + TIME_W'(1));
	assign acc_next = acc_q + {1'b0, delay_q};

	// Ring pointers
	logic [AW-1:0] newest, k_next, head_inc;
	assign newest = ring_add(head_q, AW'(DEPTH - 1));
	assign head_inc = ring_add(head_q, AW'(1));
	assign k_next = AW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	logic bs_more;
	assign bs_more = (hi_q - lo_q) > AW'(1);

	// Bracket differences
	logic [TIME_W:0] d_v, d_b, d_del;
	assign d_v   = sdiff({{(TIME_W-SAMP_W){rd_val[SAMP_W-1]}}, rd_val},
		{{(TIME_W-SAMP_W){vi_q[SAMP_W-1]}}, vi_q});
	assign d_b   = sdiff(td_q, ti_q);
	assign d_del = sdiff(rd_time, ti_q);

	// Shared multiplier, one 32x32 partial product per cycle.
	logic [SAMP_W-1:0] mul_b;
	logic [63:0] mul_p;
	assign mul_b = state_q == S_MULLO ? b_q[31:0] : b_q[63:32];
	assign mul_p = {32'd0, dv_q} * {32'd0, mul_b};

	// Restoring division step.
	logic [TIME_W:0] rem2;
	logic            div_ge;
	assign rem2 = {rem_q, p_q[PROD_W-1]};
	assign div_ge = rem2 >= {1'b0, del_q};

	// Final sum with saturation.
	logic [33:0] mag;
	logic signed [34:0] sum;
	assign mag = (ovf_q || quo_q > MAG_LIMIT) ? MAG_LIMIT : quo_q;
	assign sum = neg_q ? ($signed({{3{vi_q[SAMP_W-1]}}, vi_q}) - $signed({1'b0, mag}))
		: ($signed({{3{vi_q[SAMP_W-1]}}, vi_q}) + $signed({1'b0, mag}));

	logic [SAMP_W-1:0] sum_sat;
	always_comb begin
		if (sum > 35'sd2147483647) begin
			sum_sat = 32'h7FFF_FFFF;
		end else if (sum < -35'sd2147483648) begin
			sum_sat = 32'h8000_0000;
		end else begin
			sum_sat = sum[SAMP_W-1:0];
		end
	end

	// RAM address and write control.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {init_time, init_val_q};
		ram_raddr = head_q;
		unique case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
			end
			S_CHK: begin
				ram_raddr = newest;
			end
			S_NEWC: begin
				ram_we = 1'b1;
				ram_waddr = ($signed(now_q) > $signed(rd_time)) ? head_q : newest;
				ram_wdata = {now_q, samp_q};
			end
			S_BSI: begin
				ram_raddr = bs_more ? ring_add(k_next, head_q) : ring_add(lo_q, head_q);
			end
			S_FJ: begin
				ram_raddr = ring_add(hi_q, head_q);
			end
			default: begin
				ram_raddr = head_q;
			end
		endcase
	end

	assign s_tready = state_q == S_IDLE;
	assign cfg_ready = 1'b1;

	// A result moves into the output register when that register is free or being drained.
	logic emit_go;
	assign emit_go = (state_q == S_EMIT) && (!m_valid_q || m_tready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_W'(64'h1_0000_0000);
			init_val_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DELAY:      delay_q <= cfg_data[DELAY_W-1:0];
				REG_INIT_VALUE: init_val_q <= cfg_data[SAMP_W-1:0];
				default:        delay_q <= delay_q;
			endcase
		end
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						case (cmd_t'(s_tuser))
							CMD_INIT:  state_q <= S_INIT;
							CMD_STORE: state_q <= S_RDH;
							CMD_READ:  state_q <= S_RDH;
							default:   state_q <= S_EMIT;
						endcase
					end
				end
				S_INIT: begin
					if (idx_q == '0) begin
						head_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_RDH: state_q <= S_CHK;
				S_CHK: state_q <= (cmd_q == CMD_STORE) ? S_NEWC : S_BSI;
				S_NEWC: begin
					if ($signed(now_q) > $signed(rd_time)) begin
						head_q <= head_inc;
					end
					state_q <= S_EMIT;
				end
				S_BSI: state_q <= bs_more ? S_BSC : S_FJ;
				S_BSC: state_q <= S_BSI;
				S_FJ: state_q <= S_FGOT;
				S_FGOT: state_q <= (rd_time == ti_q) ? S_EMIT : S_MULLO;
				S_MULLO: state_q <= S_MULHI;
				S_MULHI: state_q <= S_DIV;
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= s_tuser;
				now_q <= s_tdata[TIME_W-1:0];
				samp_q <= s_tdata[TIME_W+SAMP_W-1:TIME_W];
				td_q <= td_in;
				idx_q <= AW'(DEPTH - 1);
				acc_q <= '0;
				sat_q <= 1'b0;
				res_q <= (cmd_t'(s_tuser) == CMD_INIT) ? init_val_q : '0;
				short_q <= 1'b0;
				lo_q <= '0;
				hi_q <= AW'(DEPTH - 1);
			end
			S_INIT: begin
				idx_q <= idx_q - AW'(1);
				if (!sat_q) begin
					acc_q <= acc_next;
					sat_q <= acc_next[TIME_W-1];
				end
			end
			S_CHK: begin
				short_q <= $signed(td_q) < $signed(rd_time);
			end
			S_BSI: begin
				k_q <= k_next;
			end
			S_BSC: begin
				if ($signed(td_q) < $signed(rd_time)) begin
					hi_q <= k_q;
				end else if ($signed(td_q) > $signed(rd_time)) begin
					lo_q <= k_q;
				end else begin
					lo_q <= k_q;
					hi_q <= k_q;
				end
			end
			S_FJ: begin
				ti_q <= rd_time;
				vi_q <= rd_val;
			end
			S_FGOT: begin
				res_q <= vi_q;
				dv_q <= d_v[SAMP_W-1:0];
				b_q <= d_b[TIME_W-1:0];
				del_q <= d_del[TIME_W-1:0];
				neg_q <= (d_v[TIME_W] != d_b[TIME_W]) != d_del[TIME_W];
			end
			S_MULLO: begin
				p_q <= PROD_W'(mul_p);
			end
			S_MULHI: begin
				p_q <= p_q + {mul_p, 32'd0};
				cnt_q <= CNT_W'(PROD_W - 1);
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			S_DIV: begin
				rem_q <= div_ge ? (rem2[TIME_W-1:0] - del_q) : rem2[TIME_W-1:0];
				quo_q <= {quo_q[32:0], div_ge};
				ovf_q <= ovf_q | quo_q[33];
				p_q <= {p_q[PROD_W-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			S_FIN: begin
				res_q <= sum_sat;
			end
			S_EMIT: begin
				if (!m_valid_q || m_tready) begin
					m_samp_q <= res_q;
					m_short_q <= short_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {7'd0, m_short_q, m_samp_q};

endmodule
`default_nettype wire
